[sv/rirq_pkg.sv]
// ----------------------------------------------------------------------------
// rirq_pkg
// Shared types and constants for the raster interrupt register unit.
// ----------------------------------------------------------------------------
package rirq_pkg;

    // Item kinds carried on the input tuser.
    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_READ    = 2'd1,
        REQ_TICK    = 2'd2,
        REQ_COLLIDE = 2'd3
    } req_type_t;

    // Register window.
    localparam int unsigned ADDR_W    = 6;
    localparam int unsigned REG_DEPTH = 64;

    localparam logic [ADDR_W-1:0] REG_CTRL    = 6'h11;
    localparam logic [ADDR_W-1:0] REG_RASTER  = 6'h12;
    localparam logic [ADDR_W-1:0] REG_FLAGS   = 6'h19;
    localparam logic [ADDR_W-1:0] REG_ENABLE  = 6'h1A;
    localparam logic [ADDR_W-1:0] REG_SPR_HIT = 6'h1E;
    localparam logic [ADDR_W-1:0] REG_BG_HIT  = 6'h1F;

    // Beam timing.
    localparam logic [8:0] VISIBLE_LINES   = 9'd284;
    localparam logic [8:0] LAST_LINE       = 9'd311;
    localparam logic [5:0] LAST_CYCLE      = 6'd62;
    localparam logic [5:0] COMPARE_CYCLE   = 6'd12;

    // Flag register bits.
    localparam int unsigned FLAG_RASTER = 0;
    localparam int unsigned FLAG_BG     = 1;
    localparam int unsigned FLAG_SPR    = 2;
    localparam int unsigned FLAG_ANY    = 7;

    // Bus widths.
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 32;

    // Registers kept in flip-flops rather than in the generic storage.
    function automatic logic is_special(input logic [ADDR_W-1:0] addr);
        return (addr == REG_CTRL) || (addr == REG_RASTER) || (addr == REG_FLAGS) ||
               (addr == REG_ENABLE) || (addr == REG_SPR_HIT) || (addr == REG_BG_HIT);
    endfunction

endpackage

[sv/raster_irq_register_unit.sv]
// ----------------------------------------------------------------------------
// raster_irq_register_unit
// Register window, raster beam counter and interrupt flags of a video chip.
// ----------------------------------------------------------------------------
// The unit takes one beat per clock on its input stream while the output side
// is ready and returns exactly one result beat for each, in order. Every beat
// passes an input register, where the generic register storage is read, and a
// result register, where all state is updated; the sustained rate is one beat
// per cycle whenever the output side is ready. Registers 0x11, 0x12, 0x19, 0x1A
// and the two collision latches live in flip-flops; the remaining bytes sit in a
// 64-entry memory with one valid bit per entry, so every byte reads as zero
// after reset without any clearing pass.
module raster_irq_register_unit
    import rirq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [5:0] reg_addr, [13:6] write_data, [21:14] sprite_sprite_mask,
    // [29:22] sprite_bg_mask, [31:30] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [7:0] read_data, [8] irq_raise, [9] irq_any, [10] render_line,
    // [19:11] beam_line, [25:20] beam_cycle, [31:26] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    // Input register.
    logic              st1_valid_reg;
    req_type_t         st1_type_reg;
    logic [ADDR_W-1:0] st1_addr_reg;
    logic [7:0]        st1_wdata_reg;
    logic [7:0]        st1_ss_reg;
    logic [7:0]        st1_bg_reg;

    // Generic storage read port, registered with the item.
    logic [7:0]        mem [REG_DEPTH];
    logic [7:0]        mem_q_reg;
    logic [REG_DEPTH-1:0] mem_valid_reg;
    logic [REG_DEPTH-1:0] mem_valid_next;
    logic              rd_valid_reg;
    logic              byp_reg;
    logic [7:0]        byp_data_reg;

    // Architectural state.
    logic [7:0] ctrl_reg,     ctrl_next;
    logic [7:0] raster_reg,   raster_next;
    logic [7:0] flags_reg,    flags_next;
    logic [7:0] enable_reg,   enable_next;
    logic [7:0] spr_hit_reg,  spr_hit_next;
    logic [7:0] bg_hit_reg,   bg_hit_next;
    logic [8:0] compare_reg,  compare_next;
    logic [8:0] line_reg,     line_next;
    logic [5:0] cycle_reg,    cycle_next;

    // Result register.
    logic       out_valid_reg;
    logic [7:0] out_rd_reg;
    logic       out_irq_reg;
    logic       out_any_reg;
    logic       out_render_reg;
    logic [8:0] out_line_reg;
    logic [5:0] out_cycle_reg;

    // Handshake and pipeline advance.
    logic              out_free;
    logic              proc;
    logic              s_accept;
    logic [ADDR_W-1:0] s_addr;
    logic              mem_we;
    logic              bypass;
    logic [7:0]        rd_data;
    logic              irq;
    logic              render;
    logic [7:0]        gen_rd;

    assign out_free = !out_valid_reg || m_tready;
    assign proc     = st1_valid_reg && out_free;
    assign s_tready = !st1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;
    assign s_addr   = s_tdata[ADDR_W-1:0];

    // A write to the generic storage commits when its beat is processed.
    assign mem_we = proc && (st1_type_reg == REQ_WRITE) && !is_special(st1_addr_reg);
    assign bypass = mem_we && (st1_addr_reg == s_addr);
    assign gen_rd = byp_reg ? byp_data_reg : (rd_valid_reg ? mem_q_reg : 8'h00);

    // Input register capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            st1_valid_reg <= 1'b1;
        end else if (proc) begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_type_reg  <= req_type_t'(s_tuser);
            st1_addr_reg  <= s_addr;
            st1_wdata_reg <= s_tdata[13:6];
            st1_ss_reg    <= s_tdata[21:14];
            st1_bg_reg    <= s_tdata[29:22];
            mem_q_reg     <= mem[s_addr];
            rd_valid_reg  <= mem_valid_reg[s_addr] || bypass;
            byp_reg       <= bypass;
            byp_data_reg  <= st1_wdata_reg;
        end
    end

    // Generic storage write port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[st1_addr_reg] <= st1_wdata_reg;
        end
    end

    // Next state and result of the beat in the input register.
    always_comb begin
        ctrl_next      = ctrl_reg;
        raster_next    = raster_reg;
        flags_next     = flags_reg;
        enable_next    = enable_reg;
        spr_hit_next   = spr_hit_reg;
        bg_hit_next    = bg_hit_reg;
        compare_next   = compare_reg;
        line_next      = line_reg;
        cycle_next     = cycle_reg;
        mem_valid_next = mem_valid_reg;
        rd_data        = 8'h00;
        irq            = 1'b0;
        render         = 1'b0;

        unique case (st1_type_reg)
            REQ_WRITE: begin
                unique case (st1_addr_reg)
                    REG_FLAGS: begin
                        // Acknowledge: each set low bit clears its flag.
                        flags_next = flags_reg & ~{4'h0, st1_wdata_reg[3:0]};
                        if (flags_next[3:0] == 4'h0) begin
                            flags_next[FLAG_ANY] = 1'b0;
                        end
                    end
                    REG_CTRL: begin
                        ctrl_next       = st1_wdata_reg;
                        compare_next[8] = st1_wdata_reg[7];
                    end
                    REG_RASTER: begin
                        raster_next       = st1_wdata_reg;
                        compare_next[7:0] = st1_wdata_reg;
                    end
                    REG_ENABLE: begin
                        enable_next = st1_wdata_reg;
                    end
                    REG_SPR_HIT, REG_BG_HIT: begin
                        // The stored byte is never visible through a read.
                    end
                    default: begin
                        mem_valid_next[st1_addr_reg] = 1'b1;
                    end
                endcase
            end
            REQ_READ: begin
                unique case (st1_addr_reg)
                    REG_SPR_HIT: begin
                        rd_data      = spr_hit_reg;
                        spr_hit_next = 8'h00;
                    end
                    REG_BG_HIT: begin
                        rd_data     = bg_hit_reg;
                        bg_hit_next = 8'h00;
                    end
                    REG_CTRL:   rd_data = ctrl_reg;
                    REG_RASTER: rd_data = raster_reg;
                    REG_FLAGS:  rd_data = flags_reg;
                    REG_ENABLE: rd_data = enable_reg;
                    default:    rd_data = gen_rd;
                endcase
            end
            REQ_TICK: begin
                // Mirror the line and compare it at the compare cycle.
                if (cycle_reg == COMPARE_CYCLE) begin
                    raster_next = line_reg[7:0];
                    ctrl_next   = {line_reg[8], ctrl_reg[6:0]};
                    if (enable_reg[0] && (compare_reg == line_reg)) begin
                        flags_next[FLAG_ANY]    = 1'b1;
                        flags_next[FLAG_RASTER] = 1'b1;
                        irq                     = 1'b1;
                    end
                end
                render = (line_reg < VISIBLE_LINES) && (cycle_reg == 6'd0);
                // Advance the beam.
                if (cycle_reg == LAST_CYCLE) begin
                    cycle_next = 6'd0;
                    line_next  = (line_reg == LAST_LINE) ? 9'd0 : line_reg + 9'd1;
                end else begin
                    cycle_next = cycle_reg + 6'd1;
                end
            end
            REQ_COLLIDE: begin
                // Sprite to sprite collision.
                if (st1_ss_reg != 8'h00) begin
                    spr_hit_next          = spr_hit_reg | st1_ss_reg;
                    flags_next[FLAG_SPR]  = 1'b1;
                    if (enable_reg[FLAG_SPR]) begin
                        flags_next[FLAG_ANY] = 1'b1;
                        irq                  = 1'b1;
                    end
                end
                // Sprite to background collision.
                if (st1_bg_reg != 8'h00) begin
                    bg_hit_next          = bg_hit_reg | st1_bg_reg;
                    flags_next[FLAG_BG]  = 1'b1;
                    if (enable_reg[FLAG_BG]) begin
                        flags_next[FLAG_ANY] = 1'b1;
                        irq                  = 1'b1;
                    end
                end
            end
        endcase
    end

    // State update when a beat is processed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg      <= 8'h00;
            raster_reg    <= 8'h00;
            flags_reg     <= 8'h00;
            enable_reg    <= 8'h00;
            spr_hit_reg   <= 8'h00;
            bg_hit_reg    <= 8'h00;
            compare_reg   <= 9'd0;
            line_reg      <= 9'd0;
            cycle_reg     <= 6'd0;
            mem_valid_reg <= '0;
        end else if (proc) begin
            ctrl_reg      <= ctrl_next;
            raster_reg    <= raster_next;
            flags_reg     <= flags_next;
            enable_reg    <= enable_next;
            spr_hit_reg   <= spr_hit_next;
            bg_hit_reg    <= bg_hit_next;
            compare_reg   <= compare_next;
            line_reg      <= line_next;
            cycle_reg     <= cycle_next;
            mem_valid_reg <= mem_valid_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            out_rd_reg     <= rd_data;
            out_irq_reg    <= irq;
            out_any_reg    <= flags_next[FLAG_ANY];
            out_render_reg <= render;
            out_line_reg   <= line_next;
            out_cycle_reg  <= cycle_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_cycle_reg, out_line_reg, out_render_reg,
                       out_any_reg, out_irq_reg, out_rd_reg};

endmodule

[sv/rirq_checker.sv]
// ----------------------------------------------------------------------------
// rirq_checker
// Port-level checks for the raster interrupt register unit.
// ----------------------------------------------------------------------------
module rirq_checker
    import rirq_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [1:0]           s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result beat holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // An interrupt always leaves the any-interrupt flag set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[8] || m_tdata[9])
        else $error("interrupt raised without the any flag");

    // The beam position stays inside the frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[25:20] <= LAST_CYCLE) && (m_tdata[19:11] <= LAST_LINE))
        else $error("beam position out of range");

    // A line start is reported just after cycle zero of a visible line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> (m_tdata[25:20] == 6'd1) &&
                                    (m_tdata[19:11] < VISIBLE_LINES))
        else $error("line start reported at a wrong beam position");

endmodule

bind raster_irq_register_unit rirq_checker u_rirq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
